// ----- sv/ghs_pkg.sv -----
// ----------------------------------------------------------------------------
// ghs_pkg
// Shared types, constants and helpers for the gzip header stripper.
// ----------------------------------------------------------------------------
package ghs_pkg;

    typedef enum logic [2:0] {
        PH_FIXED   = 3'd0,
        PH_XLEN    = 3'd1,
        PH_EXTRA   = 3'd2,
        PH_NAME    = 3'd3,
        PH_COMMENT = 3'd4,
        PH_HCRC    = 3'd5,
        PH_PASS    = 3'd6,
        PH_DEAD    = 3'd7
    } t_phase;

    localparam logic [7:0] MAGIC_ID1      = 8'h1F;
    localparam logic [7:0] MAGIC_ID2      = 8'h8B;
    localparam logic [7:0] METHOD_DEFLATE = 8'h08;

    localparam logic [3:0] CNT_ID1    = 4'd0;
    localparam logic [3:0] CNT_ID2    = 4'd1;
    localparam logic [3:0] CNT_METHOD = 4'd2;
    localparam logic [3:0] CNT_FLAGS  = 4'd3;
    localparam logic [3:0] CNT_LAST   = 4'd9;

    localparam int FLG_HCRC    = 1;
    localparam int FLG_EXTRA   = 2;
    localparam int FLG_NAME    = 3;
    localparam int FLG_COMMENT = 4;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       err;
    } t_result;

    // first optional part at or after from that the flags say is present
    function automatic t_phase next_phase(input t_phase from, input logic [4:0] flags);
        t_phase p;
        p = PH_PASS;
        if (from <= PH_HCRC && flags[FLG_HCRC])
            p = PH_HCRC;
        if (from <= PH_COMMENT && flags[FLG_COMMENT])
            p = PH_COMMENT;
        if (from <= PH_NAME && flags[FLG_NAME])
            p = PH_NAME;
        if (from <= PH_XLEN && flags[FLG_EXTRA])
            p = PH_XLEN;
        return p;
    endfunction

endpackage

// ----- sv/ghs_parse.sv -----
// ----------------------------------------------------------------------------
// ghs_parse
// Header parse state machine: updates the parse state on each accepted byte
// in stripping mode and decides whether the byte produces a result.
// ----------------------------------------------------------------------------
module ghs_parse
    import ghs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic       i_mode,
    input  logic [7:0] i_data,
    output t_result    o_result
);

    t_phase      r_phase,  n_phase;
    logic [3:0]  r_cnt,    n_cnt;
    logic [4:0]  r_flags,  n_flags;
    logic [15:0] r_xrem,   n_xrem;
    logic [7:0]  r_xlow,   n_xlow;
    logic        r_bad,    n_bad;
    logic [15:0] xlen;
    logic [15:0] xdec;

    assign xlen = {i_data, r_xlow};
    assign xdec = r_xrem - 16'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIXED;
            r_cnt   <= '0;
            r_flags <= '0;
            r_xrem  <= '0;
            r_xlow  <= '0;
            r_bad   <= 1'b0;
        end else if (i_accept && i_mode) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_flags <= n_flags;
            r_xrem  <= n_xrem;
            r_xlow  <= n_xlow;
            r_bad   <= n_bad;
        end
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_flags = r_flags;
        n_xrem  = r_xrem;
        n_xlow  = r_xlow;
        n_bad   = r_bad;
        unique case (r_phase)
            PH_FIXED: begin
                if (r_cnt == CNT_ID1 && i_data != MAGIC_ID1)
                    n_bad = 1'b1;
                if (r_cnt == CNT_ID2 && i_data != MAGIC_ID2)
                    n_bad = 1'b1;
                if (r_cnt == CNT_METHOD && i_data != METHOD_DEFLATE)
                    n_bad = 1'b1;
                if (r_cnt == CNT_FLAGS) begin
                    if (i_data[7:5] != 3'd0)
                        n_bad = 1'b1;
                    n_flags = i_data[4:0];
                end
                if (r_cnt >= CNT_LAST) begin
                    n_cnt   = '0;
                    n_phase = r_bad ? PH_DEAD : next_phase(PH_XLEN, r_flags);
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            PH_XLEN: begin
                if (r_cnt == 4'd0) begin
                    n_xlow = i_data;
                    n_cnt  = 4'd1;
                end else begin
                    n_xrem  = xlen;
                    n_cnt   = '0;
                    n_phase = (xlen == 16'd0) ? next_phase(PH_NAME, r_flags) : PH_EXTRA;
                end
            end
            PH_EXTRA: begin
                n_xrem = xdec;
                if (xdec == 16'd0) begin
                    n_phase = next_phase(PH_NAME, r_flags);
                    n_cnt   = '0;
                end
            end
            PH_NAME: begin
                if (i_data == 8'd0) begin
                    n_phase = next_phase(PH_COMMENT, r_flags);
                    n_cnt   = '0;
                end
            end
            PH_COMMENT: begin
                if (i_data == 8'd0) begin
                    n_phase = next_phase(PH_HCRC, r_flags);
                    n_cnt   = '0;
                end
            end
            PH_HCRC: begin
                if (r_cnt == 4'd0) begin
                    n_cnt = 4'd1;
                end else begin
                    n_phase = PH_PASS;
                    n_cnt   = '0;
                end
            end
            PH_PASS: begin
            end
            PH_DEAD: begin
            end
            default: begin
            end
        endcase
    end

    // result for the byte presented now
    always_comb begin
        o_result = '0;
        if (!i_mode) begin
            o_result.valid = i_accept;
            o_result.data  = i_data;
        end else begin
            unique case (r_phase)
                PH_FIXED: begin
                    if (r_cnt >= CNT_LAST && r_bad) begin
                        o_result.valid = i_accept;
                        o_result.err   = 1'b1;
                    end
                end
                PH_PASS: begin
                    o_result.valid = i_accept;
                    o_result.data  = i_data;
                end
                default: begin
                end
            endcase
        end
    end

    a_dead_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_mode && r_phase == PH_DEAD) |-> !o_result.valid)
        else $error("result produced after a bad header");

    a_dead_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DEAD) |=> (r_phase == PH_DEAD))
        else $error("left the dead phase without reset");

    a_err_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.err |-> (r_bad && r_cnt == CNT_LAST && o_result.data == 8'd0))
        else $error("error result outside the tenth header byte");

endmodule

// ----- sv/ghs_out_buf.sv -----
// ----------------------------------------------------------------------------
// ghs_out_buf
// Two-entry output register with skid stage, so the input side can keep
// accepting while a result waits for the receiver.
// ----------------------------------------------------------------------------
module ghs_out_buf
    import ghs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_result    i_push,
    output logic       o_room,
    output logic       o_valid,
    output logic [7:0] o_data,
    output logic       o_err,
    input  logic       i_ready
)
;
    logic       r_main_valid;
    logic       r_skid_valid;
    logic [7:0] r_main_data, r_skid_data;
    logic       r_main_err,  r_skid_err;
    logic       pop;

    assign pop     = r_main_valid && i_ready;
    assign o_room  = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main_data;
    assign o_err   = r_main_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                // no push can arrive while the skid entry is full
                if (pop) begin
                    r_main_valid <= 1'b1;
                    r_skid_valid <= 1'b0;
                end
            end else if (i_push.valid) begin
                if (!r_main_valid || pop) begin
                    r_main_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (pop) begin
                r_main_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_main_data <= r_skid_data;
                r_main_err  <= r_skid_err;
            end
        end else if (i_push.valid) begin
            if (!r_main_valid || pop) begin
                r_main_data <= i_push.data;
                r_main_err  <= i_push.err;
            end else begin
                r_skid_data <= i_push.data;
                r_skid_err  <= i_push.err;
            end
        end
    end

    a_skid_behind_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid entry holds an item with the main register empty");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid |-> !r_skid_valid)
        else $error("item pushed into a full output buffer");

    a_skid_moves_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_ready) |=> (r_main_valid && !r_skid_valid))
        else $error("skid item not moved up after the main item was taken");

endmodule

// ----- sv/gzip_header_stripper.sv -----
// ----------------------------------------------------------------------------
// gzip_header_stripper
// Strips a gzip member header from a byte stream and passes the payload on.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_in_valid / o_in_ready carries one byte per item on
//   i_data_byte. Output channel o_out_valid / i_out_ready carries result
//   items: o_out_byte with o_is_error. Header bytes give no result; payload
//   bytes come out unchanged; a bad header gives a single error item (byte
//   zero) on the tenth byte, after which all input is swallowed until reset.
//   i_cfg_we / i_cfg_data writes the mode bit (1 strips the header, 0 passes
//   every byte); write it only while the block is idle.
//   Throughput is one byte per cycle while o_in_ready is high. A result is
//   formed combinationally from the accepted byte and the parse state and
//   is registered in the output buffer. A two-entry output buffer lets the
//   input keep flowing while the receiver stalls; o_in_ready drops only
//   while both entries are full.
//   Reset (synchronous, active low) restarts header parsing, sets the mode
//   to stripping and empties the output buffer.
// ----------------------------------------------------------------------------
module gzip_header_stripper
    import ghs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_is_error
);

    logic    r_header_mode;
    logic    accept;
    t_result result;

    assign accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_mode <= 1'b1;
        end else if (i_cfg_we) begin
            r_header_mode <= i_cfg_data;
        end
    end

    ghs_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_mode   (r_header_mode),
        .i_data   (i_data_byte),
        .o_result (result)
    );

    ghs_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (result),
        .o_room  (o_in_ready),
        .o_valid (o_out_valid),
        .o_data  (o_out_byte),
        .o_err   (o_is_error),
        .i_ready (i_out_ready)
    );

endmodule
